[src/fbfl_pkg.sv]
// Shared constants for the fixed block free list allocator.
package fbfl_pkg;

    // Operation codes of an input transaction.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes of a result transaction.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_BAD_FREE = 2'd2;

    // Block size register: width, upper bound and log2 of the upper bound.
    localparam int unsigned BB_W     = 13;
    localparam int unsigned BB_SHIFT = 12;
    localparam logic [BB_W-1:0] BB_RESET = 13'd8;
    localparam logic [BB_W-1:0] BB_MAX   = 13'd4096;

endpackage

[src/fixed_block_free_list_allocator.sv]
// Fixed block free list allocator: top level with sequencer, link memory and multiplier.
// Free and rejected requests: result valid in the cycle after the input transaction.
// Allocate: result valid after the bit-serial offset multiply has finished.
// One transaction at a time, ready the cycle after the result is taken.
// Sync active-low reset, then a link pass over every entry; config taken during it, requests not.
module fixed_block_free_list_allocator
    import fbfl_pkg::*;
#(
    parameter int unsigned BLOCKS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [BB_W-1:0]                   i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [$clog2(BLOCKS)-1:0]         i_freed_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [$clog2(BLOCKS)-1:0]         o_granted_index,
    output logic [$clog2(BLOCKS)+BB_SHIFT-1:0] o_byte_offset,
    output logic [$clog2(BLOCKS+1)-1:0]       o_blocks_in_use
);

    localparam int unsigned IDX_W  = $clog2(BLOCKS);
    localparam int unsigned LINK_W = $clog2(BLOCKS + 1);
    localparam int unsigned CNT_W  = $clog2(BLOCKS + 1);
    localparam int unsigned OFS_W  = IDX_W + BB_SHIFT;
    localparam int unsigned PROD_W = IDX_W + BB_W;
    localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(BLOCKS);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(BLOCKS);
    localparam logic [IDX_W-1:0]  LAST_ADDR = IDX_W'(BLOCKS - 1);

    // Sequencer states.
    localparam logic [1:0] S_INIT  = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_init_addr, n_init_addr;
    logic [IDX_W-1:0]  r_head, n_head;
    logic              r_head_vld, n_head_vld;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [BB_W-1:0]   r_block_bytes;
    logic              r_out_vld, n_out_vld;
    logic [1:0]        r_status, n_status;
    logic [IDX_W-1:0]  r_grant, n_grant;
    logic [OFS_W-1:0]  r_offset, n_offset;
    logic [CNT_W-1:0]  r_out_count, n_out_count;

    logic              in_fire;
    logic              bad_free;
    logic [CNT_W-1:0]  count_inc;
    logic [BB_W-1:0]   bb_sat;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic              mem_re;
    logic [LINK_W-1:0] link;
    logic              mul_start;
    logic              mul_done;
    logic [PROD_W-1:0] mul_product;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_vld;
    assign in_fire    = i_in_valid && o_in_ready;
    assign bad_free   = (32'(i_freed_index) >= BLOCKS) || (r_count == '0);
    assign count_inc  = r_count + CNT_W'(1);
    assign bb_sat     = (r_block_bytes > BB_MAX) ? BB_MAX : r_block_bytes;

    // Link memory: one entry per block, holding the next free block or the end mark.
    fbfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_head),
        .o_rdata (link)
    );

    // Byte offset of the granted block.
    fbfl_mul #(
        .IDX_W  (IDX_W),
        .PROD_W (PROD_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (bb_sat),
        .i_mplier  (r_head),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    // Sequencer and free list update.
    always_comb begin
        n_state     = r_state;
        n_init_addr = r_init_addr;
        n_head      = r_head;
        n_head_vld  = r_head_vld;
        n_count     = r_count;
        n_out_vld   = r_out_vld && !i_out_ready;
        n_status    = r_status;
        n_grant     = r_grant;
        n_offset    = r_offset;
        n_out_count = r_out_count;
        mem_we      = 1'b0;
        mem_waddr   = r_init_addr;
        mem_wdata   = LINK_W'(r_init_addr) + LINK_W'(1);
        mem_re      = 1'b0;
        mul_start   = 1'b0;

        unique case (r_state)
            S_INIT: begin
                mem_we      = 1'b1;
                n_init_addr = r_init_addr + IDX_W'(1);
                if (r_init_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_grant  = '0;
                    n_offset = '0;
                    if (i_operation == OP_ALLOC) begin
                        if (r_head_vld) begin
                            mem_re    = 1'b1;
                            mul_start = 1'b1;
                            n_state   = S_ALLOC;
                        end else begin
                            n_out_vld   = 1'b1;
                            n_status    = STAT_EMPTY;
                            n_out_count = r_count;
                        end
                    end else if (bad_free) begin
                        n_out_vld   = 1'b1;
                        n_status    = STAT_BAD_FREE;
                        n_out_count = r_count;
                    end else begin
                        // Push the freed block in front of the old head.
                        mem_we      = 1'b1;
                        mem_waddr   = i_freed_index;
                        mem_wdata   = r_head_vld ? LINK_W'(r_head) : LINK_END;
                        n_head      = i_freed_index;
                        n_head_vld  = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                        n_out_vld   = 1'b1;
                        n_status    = STAT_OK;
                        n_out_count = r_count - CNT_W'(1);
                    end
                end
            end
            S_ALLOC: begin
                if (mul_done) begin
                    // Pop the head; the link read has completed by now.
                    n_state     = S_IDLE;
                    n_out_vld   = 1'b1;
                    n_status    = STAT_OK;
                    n_grant     = r_head;
                    n_offset    = mul_product[OFS_W-1:0];
                    n_out_count = count_inc;
                    n_count     = count_inc;
                    if (count_inc < CNT_FULL) begin
                        n_head     = link[IDX_W-1:0];
                        n_head_vld = link < LINK_END;
                    end else begin
                        n_head_vld = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_init_addr   <= '0;
            r_head        <= '0;
            r_head_vld    <= 1'b1;
            r_count       <= '0;
            r_out_vld     <= 1'b0;
            r_block_bytes <= BB_RESET;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_head      <= n_head;
            r_head_vld  <= n_head_vld;
            r_count     <= n_count;
            r_out_vld   <= n_out_vld;
            if (i_cfg_we) begin
                r_block_bytes <= i_cfg_wdata;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_grant     <= n_grant;
        r_offset    <= n_offset;
        r_out_count <= n_out_count;
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_status;
    assign o_granted_index = r_grant;
    assign o_byte_offset   = r_offset;
    assign o_blocks_in_use = r_out_count;

endmodule

[src/fbfl_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module fbfl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/fbfl_mul.sv]
// Iterative shift-add multiplier: one multiplier bit per cycle.
module fbfl_mul
    import fbfl_pkg::*;
#(
    parameter int unsigned IDX_W  = 6,
    parameter int unsigned PROD_W = 19
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [BB_W-1:0]   i_mcand,
    input  logic [IDX_W-1:0]  i_mplier,
    output logic              o_done,
    output logic [PROD_W-1:0] o_product
);

    localparam int unsigned CNT_W = $clog2(IDX_W + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(IDX_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_mcand;
    logic [IDX_W-1:0]  r_mplier;

    // Step control: load on start, count down one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand when the low multiplier bit is set.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= PROD_W'(i_mcand);
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

[src/fbfl_chk.sv]
// Port-level checker for the fixed block free list allocator, with its bind statement.
module fbfl_chk
    import fbfl_pkg::*;
#(
    parameter int unsigned BLOCKS = 64
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [1:0]                         o_status,
    input logic [$clog2(BLOCKS)-1:0]          o_granted_index,
    input logic [$clog2(BLOCKS)+BB_SHIFT-1:0] o_byte_offset,
    input logic [$clog2(BLOCKS+1)-1:0]        o_blocks_in_use
);

    // A result that waits for the consumer keeps its status, byte offset and blocks-in-use count.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_blocks_in_use)
             && $stable(o_byte_offset)))
        else $error("result changed while stalled");

    // The block never takes a new transaction while a result is pending.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // After an accepted transaction the block is not ready in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted transaction");

    // Only a successful grant carries a nonzero index or offset.
    a_no_grant_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STAT_OK) |->
            (o_granted_index == '0 && o_byte_offset == '0))
        else $error("index or offset on a failed request");

    // The count of blocks in use never exceeds the pool size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_blocks_in_use) <= BLOCKS))
        else $error("blocks in use above pool size");

endmodule

bind fixed_block_free_list_allocator fbfl_chk #(.BLOCKS(BLOCKS)) u_fbfl_chk (.*);

[sim/tb.sv]
// Self-checking testbench for the fixed block free list allocator.
`timescale 1ns / 100ps

module tb;
    import fbfl_pkg::*;

    localparam int unsigned BLOCKS = 64;
    localparam int unsigned IDX_W  = $clog2(BLOCKS);
    localparam int unsigned OFS_W  = IDX_W + BB_SHIFT;
    localparam int unsigned CNT_W  = $clog2(BLOCKS + 1);

    // Pool copies: one tracks the block, one plans the stimulus.
    localparam int MODEL = 0;
    localparam int PLAN  = 1;

    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_AFTER   = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] idx;
    } t_request;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted;
        logic [OFS_W-1:0] offset;
        logic [CNT_W-1:0] count;
    } t_outcome;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [BB_W-1:0]  i_cfg_wdata = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_operation = OP_ALLOC;
    logic [IDX_W-1:0] i_freed_index = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [1:0]       o_status;
    logic [IDX_W-1:0] o_granted_index;
    logic [OFS_W-1:0] o_byte_offset;
    logic [CNT_W-1:0] o_blocks_in_use;

    // Pool state, indexed by copy.
    int unsigned link_mem [2][BLOCKS];
    int unsigned head_at [2];
    bit          head_ok [2];
    int unsigned in_use [2];
    logic [BB_W-1:0] block_size;

    t_request         pending_requests[$];
    t_outcome         awaited_results[$];
    logic [IDX_W-1:0] held_blocks[$];

    bit          quiet = 1'b0;
    bit          in_took = 1'b0;
    bit          out_took = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;

    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned granted_cnt = 0;
    int unsigned empty_cnt = 0;
    int unsigned freed_cnt = 0;
    int unsigned bad_free_cnt = 0;
    int unsigned cfg_writes = 0;

    fixed_block_free_list_allocator #(.BLOCKS(BLOCKS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_freed_index   (i_freed_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_byte_offset   (o_byte_offset),
        .o_blocks_in_use (o_blocks_in_use)
    );

    // Clock generation.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Return one copy of the pool to its post-reset state.
    function automatic void pool_clear(input int s);
        for (int i = 0; i < BLOCKS; i++) begin
            link_mem[s][i] = i + 1;
        end
        head_at[s] = 0;
        head_ok[s] = 1'b1;
        in_use[s] = 0;
    endfunction

    // Apply one request to a copy of the pool and return the answer it gets.
    function automatic t_outcome pool_step(input int s, input logic op,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [BB_W-1:0] bb);
        t_outcome    r;
        int unsigned eff;
        int unsigned ofs;
        r = '0;
        if (op == OP_ALLOC) begin
            if (head_ok[s] && head_at[s] < BLOCKS) begin
                // Sizes above the upper bound saturate.
                eff = (bb > BB_MAX) ? 32'(BB_MAX) : 32'(bb);
                ofs = head_at[s] * eff;
                r.granted = head_at[s][IDX_W-1:0];
                r.offset = ofs[OFS_W-1:0];
                in_use[s]++;
                if (in_use[s] < BLOCKS) begin
                    head_at[s] = link_mem[s][r.granted];
                    head_ok[s] = head_at[s] < BLOCKS;
                end else begin
                    head_ok[s] = 1'b0;
                end
            end else begin
                r.status = STAT_EMPTY;
            end
        end else if (idx >= BLOCKS || in_use[s] == 0) begin
            r.status = STAT_BAD_FREE;
        end else begin
            // The freed block goes on top and links to the old head.
            link_mem[s][idx] = head_ok[s] ? head_at[s] : BLOCKS;
            head_at[s] = idx;
            head_ok[s] = 1'b1;
            in_use[s]--;
        end
        r.count = in_use[s][CNT_W-1:0];
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Report one mismatch and count it.
    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 100) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // Queue a request and track which blocks the plan believes are held.
    task automatic add_request(input logic op, input logic [IDX_W-1:0] idx);
        t_outcome r;
        t_request q;
        int       k;
        r = pool_step(PLAN, op, idx, '0);
        if (op == OP_ALLOC && r.status == STAT_OK) begin
            held_blocks.push_back(r.granted);
        end else if (op == OP_FREE && r.status == STAT_OK) begin
            k = 0;
            while (k < held_blocks.size() && held_blocks[k] != idx) begin
                k++;
            end
            if (k < held_blocks.size()) begin
                held_blocks.delete(k);
            end
        end
        q.op = op;
        q.idx = idx;
        pending_requests.push_back(q);
    endtask

    // Write the block size register at a falling edge.
    task automatic write_block_size(input logic [BB_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every request is answered, then let the block settle.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || awaited_results.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Request driver: offers the next pending transaction after a random gap.
    always @(negedge i_clk) begin
        t_request q;
        logic     nv;
        nv = i_in_valid && !in_took;
        if (!nv) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_requests.size() != 0) begin
                q = pending_requests.pop_front();
                nv = 1'b1;
                i_operation <= q.op;
                i_freed_index <= q.idx;
                send_gap = pick_gap();
            end
        end
        i_in_valid <= nv;
    end

    // Result receiver: random stalls plus one long hold-off that backs up the input.
    always @(negedge i_clk) begin
        logic nr;
        nr = 1'b1;
        if (out_took) begin
            stall_left = pick_gap();
        end
        if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            nr = 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall_left = pick_gap();
            nr = (stall_left == 0);
        end
        i_out_ready <= nr;
    end

    // Monitor: tracks config writes, checks results and predicts accepted requests.
    always @(posedge i_clk) begin
        t_outcome e;
        if (!i_rst_n) begin
            pool_clear(MODEL);
            block_size = BB_RESET;
            in_took = 1'b0;
            out_took = 1'b0;
        end else begin
            if (i_cfg_we) begin
                block_size = i_cfg_wdata;
                cfg_writes++;
            end

            // Result transaction against the oldest expectation.
            out_took = o_out_valid && i_out_ready;
            if (out_took) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report("result transaction with nothing expected");
                end else begin
                    e = awaited_results.pop_front();
                    if (o_status !== e.status) begin
                        report($sformatf("status got %0d exp %0d", o_status, e.status));
                    end
                    if (o_granted_index !== e.granted) begin
                        report($sformatf("granted_index got %0d exp %0d",
                                         o_granted_index, e.granted));
                    end
                    if (o_byte_offset !== e.offset) begin
                        report($sformatf("byte_offset got %0d exp %0d",
                                         o_byte_offset, e.offset));
                    end
                    if (o_blocks_in_use !== e.count) begin
                        report($sformatf("blocks_in_use got %0d exp %0d",
                                         o_blocks_in_use, e.count));
                    end
                end
            end

            // Request transaction: predict its answer.
            in_took = i_in_valid && o_in_ready;
            if (in_took) begin
                e = pool_step(MODEL, i_operation, i_freed_index, block_size);
                awaited_results.push_back(e);
                case (e.status)
                    STAT_EMPTY:    empty_cnt++;
                    STAT_BAD_FREE: bad_free_cnt++;
                    default: begin
                        if (i_operation == OP_ALLOC) begin
                            granted_cnt++;
                        end else begin
                            freed_cnt++;
                        end
                    end
                endcase
            end
        end
    end

    // Stimulus: directed opening, then phases of random traffic under different sizes.
    initial begin
        logic [BB_W-1:0] bb;
        int unsigned     alloc_pct;
        logic [IDX_W-1:0] idx;
        int unsigned     k;

        pool_clear(PLAN);
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: free on an empty count, allocs, double free, both index extremes.
        write_block_size(13'd3);
        add_request(OP_FREE, 6'd63);
        add_request(OP_FREE, 6'd0);
        add_request(OP_ALLOC, 6'd63);
        add_request(OP_ALLOC, 6'd0);
        add_request(OP_ALLOC, 6'd42);
        add_request(OP_FREE, 6'd1);
        add_request(OP_FREE, 6'd1);
        add_request(OP_ALLOC, 6'd21);
        add_request(OP_ALLOC, 6'd0);
        add_request(OP_FREE, 6'd0);
        add_request(OP_FREE, 6'd63);
        add_request(OP_FREE, 6'd2);
        add_request(OP_ALLOC, 6'd0);
        add_request(OP_ALLOC, 6'd63);
        add_request(OP_FREE, 6'd63);
        add_request(OP_FREE, 6'd1);
        add_request(OP_FREE, 6'd0);
        add_request(OP_FREE, 6'd5);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: bb = 13'd1;
                1: bb = BB_MAX;
                2: bb = '0;
                3: bb = 13'd8191;
                4: bb = 13'd4097;
                5: bb = BB_W'($urandom_range(1, 4096));
                default: bb = BB_W'($urandom_range(0, 8191));
            endcase
            // Cycle through fill-heavy, balanced and drain-heavy traffic so both ends of the pool are hit.
            case (ph % 3)
                0: alloc_pct = 85;
                1: alloc_pct = 50;
                default: alloc_pct = 15;
            endcase
            quiet = (ph == 2 || ph == 5);
            write_block_size(bb);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < alloc_pct) begin
                    add_request(OP_ALLOC, IDX_W'($urandom_range(0, BLOCKS - 1)));
                end else begin
                    if (held_blocks.size() != 0 && $urandom_range(0, 99) < 85) begin
                        k = $urandom_range(0, held_blocks.size() - 1);
                        idx = held_blocks[k];
                    end else begin
                        idx = IDX_W'($urandom_range(0, BLOCKS - 1));
                    end
                    add_request(OP_FREE, idx);
                end
            end
            wait_idle();
        end

        $display("Covered %0d results: %0d grants, %0d pool-empty, %0d frees,",
                 results_seen, granted_cnt, empty_cnt, freed_cnt);
        $display("%0d rejected frees; block size written %0d times, zero up to saturation.",
                 bad_free_cnt, cfg_writes);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20000000;
        $display("Timeout with %0d results still expected.", awaited_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

[fixed_block_free_list_allocator.f]
src/fbfl_pkg.sv
src/fbfl_ram.sv
src/fbfl_mul.sv
src/fixed_block_free_list_allocator.sv
src/fbfl_chk.sv
sim/tb.sv
